@@ hdl/decimal_value_glyph_renderer_macros.svh @@
// Assertion macros for the glyph renderer checker.
// Expects signals named clock and reset in the scope of use.
`ifndef DECIMAL_VALUE_GLYPH_RENDERER_MACROS_SVH
`define DECIMAL_VALUE_GLYPH_RENDERER_MACROS_SVH

// Same-cycle implication
`define DVGR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dvgr check failed");

// Next-cycle implication
`define DVGR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dvgr check failed");

`endif

@@ hdl/dvgr_pkg.sv @@
// Types, constants and 5x7 font table for the glyph renderer.
// No dependencies.
package dvgr_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } dvgr_state_type;

   typedef struct packed {
      logic [6:0] col_a;
      logic [6:0] col_b;
      logic [6:0] col_c;
      logic [6:0] col_d;
      logic [6:0] col_e;
   } glyph_type;

   localparam int          NUM_BITS    = 32;
   localparam int          BIT_CNT_W   = 5;
   localparam logic [4:0]  LAST_BIT    = 5'd31;
   localparam logic [7:0]  FONT_FIRST  = 8'h20;
   localparam logic [7:0]  ASCII_ZERO  = 8'h30;
   localparam logic [3:0]  BCD_FIX_MIN = 4'd5;
   localparam logic [3:0]  BCD_FIX_ADD = 4'd3;

   localparam logic [39:0] FONT_TABLE [0:95] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
   };

   function automatic logic font_bad(input logic [7:0] code);
      return (code < FONT_FIRST) || code[7];
   endfunction

   function automatic glyph_type font_glyph(input logic [7:0] code);
      logic [6:0]  idx;
      logic [39:0] row;
      glyph_type   g;
      idx = code[6:0] - FONT_FIRST[6:0];
      row = font_bad(code) ? 40'h0 : FONT_TABLE[idx];
      g.col_a = row[38:32];
      g.col_b = row[30:24];
      g.col_c = row[22:16];
      g.col_d = row[14:8];
      g.col_e = row[6:0];
      return g;
   endfunction

endpackage

@@ hdl/decimal_value_glyph_renderer.sv @@
// Top level: 5x7 glyph renderer with serial binary-to-BCD value conversion; uses dvgr_pkg.
// Character mode: the item is taken in ST_IDLE and its glyph is registered in ST_EMIT
// once the output is free. Value mode: one shift-and-correct step per input bit (ST_CONV),
// leading zero digits dropped (ST_SKIP), then one digit per cycle while rsp_stall is low.
// In both modes req_stall stays high until the sequencer is back in ST_IDLE.
// Synchronous reset clears the sequencer and rsp_valid; data registers are not reset.
module decimal_value_glyph_renderer #(
   parameter int MAX_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_char_code,
   input  logic [31:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_col_pad_left,
   output logic [6:0]  rsp_col_a,
   output logic [6:0]  rsp_col_b,
   output logic [6:0]  rsp_col_c,
   output logic [6:0]  rsp_col_d,
   output logic [6:0]  rsp_col_e,
   output logic        rsp_col_pad_right,
   output logic [7:0]  rsp_shown_code,
   output logic        rsp_bad_code,
   output logic        rsp_last
);
   import dvgr_pkg::*;

   localparam int DW = 4 * MAX_DIGITS;
   localparam int CW = $clog2(MAX_DIGITS + 1);

   dvgr_state_type       state_ff, state_in;
   logic [DW-1:0]        bcd_ff, bcd_in;
   logic [31:0]          bin_ff, bin_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 over_ff, over_in;
   logic [CW-1:0]        left_ff, left_in;
   logic                 char_mode_ff, char_mode_in;
   logic [7:0]           code_ff, code_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   glyph_type            glyph_ff, glyph_in;
   logic [7:0]           shown_ff, shown_in;
   logic                 bad_ff, bad_in;
   logic                 last_ff, last_in;

   logic [DW-1:0]        dabble_adj;
   logic [7:0]           emit_code;
   logic                 out_free;
   logic                 load;

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         dabble_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= BCD_FIX_MIN) ?
                                bcd_ff[4*i +: 4] + BCD_FIX_ADD : bcd_ff[4*i +: 4];
      end
   end

   assign emit_code = char_mode_ff ? code_ff : (ASCII_ZERO | {4'b0, bcd_ff[DW-1 -: 4]});
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bcd_ff       <= bcd_in;
      bin_ff       <= bin_in;
      bit_cnt_ff   <= bit_cnt_in;
      over_ff      <= over_in;
      left_ff      <= left_in;
      char_mode_ff <= char_mode_in;
      code_ff      <= code_in;
      glyph_ff     <= glyph_in;
      shown_ff     <= shown_in;
      bad_ff       <= bad_in;
      last_ff      <= last_in;
   end

   always_comb begin
      state_in     = state_ff;
      bcd_in       = bcd_ff;
      bin_in       = bin_ff;
      bit_cnt_in   = bit_cnt_ff;
      over_in      = over_ff;
      left_in      = left_ff;
      char_mode_in = char_mode_ff;
      code_in      = code_ff;
      load         = 1'b0;
      last_in      = last_ff;
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in      = req_char_code;
               bin_in       = req_number;
               bcd_in       = '0;
               over_in      = 1'b0;
               bit_cnt_in   = '0;
               left_in      = CW'(1);
               char_mode_in = !req_func;
               state_in     = req_func ? ST_CONV : ST_EMIT;
            end
         end
         ST_CONV: begin
            bcd_in     = {dabble_adj[DW-2:0], bin_ff[NUM_BITS-1]};
            bin_in     = bin_ff << 1;
            over_in    = over_ff | dabble_adj[DW-1];
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == LAST_BIT) begin
               left_in  = CW'(MAX_DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((bcd_ff[DW-1 -: 4] == 4'd0) && !over_ff && (left_ff > CW'(1))) begin
               bcd_in  = bcd_ff << 4;
               left_in = left_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load    = 1'b1;
               last_in = (left_ff == CW'(1));
               bcd_in  = bcd_ff << 4;
               left_in = left_ff - 1'b1;
               if (left_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      glyph_in = load ? font_glyph(emit_code) : glyph_ff;
      shown_in = load ? emit_code : shown_ff;
      bad_in   = load ? font_bad(emit_code) : bad_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_col_pad_left  = 1'b0;
   assign rsp_col_a         = glyph_ff.col_a;
   assign rsp_col_b         = glyph_ff.col_b;
   assign rsp_col_c         = glyph_ff.col_c;
   assign rsp_col_d         = glyph_ff.col_d;
   assign rsp_col_e         = glyph_ff.col_e;
   assign rsp_col_pad_right = 1'b0;
   assign rsp_shown_code    = shown_ff;
   assign rsp_bad_code      = bad_ff;
   assign rsp_last          = last_ff;

endmodule

@@ hdl/dvgr_checker.sv @@
// Port-level checker for the glyph renderer, bound to the top level.
// Depends on decimal_value_glyph_renderer_macros.svh and dvgr_pkg.
`include "decimal_value_glyph_renderer_macros.svh"

module dvgr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_func,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_col_a,
   input logic [6:0]  rsp_col_b,
   input logic [6:0]  rsp_col_c,
   input logic [6:0]  rsp_col_d,
   input logic [6:0]  rsp_col_e,
   input logic [7:0]  rsp_shown_code,
   input logic        rsp_bad_code,
   input logic        rsp_last
);
   import dvgr_pkg::*;

   logic       code_bad;
   logic [6:0] cols_any;

   assign code_bad = font_bad(rsp_shown_code);
   assign cols_any = rsp_col_a | rsp_col_b | rsp_col_c | rsp_col_d | rsp_col_e;

   `DVGR_ASSERT_IMP(a_idle_after_reset, $past(reset), !rsp_valid && !req_stall)

   `DVGR_ASSERT_NXT(a_busy_on_value, req_valid && !req_stall && req_func, req_stall)

   `DVGR_ASSERT_IMP(a_bad_flag, rsp_valid, rsp_bad_code == code_bad)

   `DVGR_ASSERT_IMP(a_bad_blank, rsp_valid && rsp_bad_code, cols_any == 7'd0)

   `DVGR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_shown_code) && $stable(rsp_last))

endmodule

bind decimal_value_glyph_renderer dvgr_checker u_dvgr_checker (.*);

@@ sim/decimal_value_glyph_renderer_test.sv @@
// Self-checking testbench for decimal_value_glyph_renderer: directed and random
// character and value items, with results checked against an in-bench glyph predictor.
// Depends on the RTL top level only; the font table is held locally.
module decimal_value_glyph_renderer_test;

   localparam int MAX_DIGITS   = 10;
   localparam int IDLE_PCT     = 13;
   localparam int DRAIN_CYCLES = 60;
   localparam int REPORT_MAX   = 10;
   localparam logic FUNC_CHAR  = 1'b0;
   localparam logic FUNC_VALUE = 1'b1;
   localparam logic [7:0] CODE_SPACE = 8'h20;
   localparam logic [7:0] CODE_DEL   = 8'h7f;
   localparam logic [7:0] CODE_ZERO  = 8'h30;

   typedef struct packed {
      logic       col_pad_left;
      logic [6:0] col_a;
      logic [6:0] col_b;
      logic [6:0] col_c;
      logic [6:0] col_d;
      logic [6:0] col_e;
      logic       col_pad_right;
      logic [7:0] shown_code;
      logic       bad_code;
      logic       last;
   } glyph_result_t;

   localparam logic [39:0] GLYPH_ROWS [0:95] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [7:0]  req_char_code = 8'h00;
   logic [31:0] req_number = 32'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_col_pad_left;
   logic [6:0]  rsp_col_a;
   logic [6:0]  rsp_col_b;
   logic [6:0]  rsp_col_c;
   logic [6:0]  rsp_col_d;
   logic [6:0]  rsp_col_e;
   logic        rsp_col_pad_right;
   logic [7:0]  rsp_shown_code;
   logic        rsp_bad_code;
   logic        rsp_last;

   glyph_result_t expected_glyphs [$];
   bit quiet = 1'b0;
   int failures = 0;
   int reported = 0;
   int n_chars = 0;
   int n_values = 0;
   int n_glyphs = 0;

   decimal_value_glyph_renderer #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_char_code(req_char_code),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_col_pad_left(rsp_col_pad_left),
      .rsp_col_a(rsp_col_a),
      .rsp_col_b(rsp_col_b),
      .rsp_col_c(rsp_col_c),
      .rsp_col_d(rsp_col_d),
      .rsp_col_e(rsp_col_e),
      .rsp_col_pad_right(rsp_col_pad_right),
      .rsp_shown_code(rsp_shown_code),
      .rsp_bad_code(rsp_bad_code),
      .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic glyph_result_t render_glyph(input logic [7:0] code, input bit is_last);
      glyph_result_t g;
      logic [39:0]   row;
      logic [6:0]    idx;
      g.bad_code = (code < CODE_SPACE) || (code > CODE_DEL);
      idx = 7'(code - CODE_SPACE);
      row = g.bad_code ? 40'h0 : GLYPH_ROWS[idx];
      g.col_pad_left  = 1'b0;
      g.col_a         = row[38:32];
      g.col_b         = row[30:24];
      g.col_c         = row[22:16];
      g.col_d         = row[14:8];
      g.col_e         = row[6:0];
      g.col_pad_right = 1'b0;
      g.shown_code    = code;
      g.last          = is_last;
      return g;
   endfunction

   task automatic predict_request(input logic func, input logic [7:0] code,
                                  input logic [31:0] number);
      logic [3:0]  digits [MAX_DIGITS];
      logic [31:0] v;
      int          n;
      n = 0;
      if (func == FUNC_CHAR) begin
         expected_glyphs.push_back(render_glyph(code, 1'b1));
         n_chars++;
      end else begin
         v = number;
         do begin
            digits[n] = 4'(v % 10);
            n++;
            v = v / 10;
         end while (v != 0 && n < MAX_DIGITS);
         for (int k = 0; k < n; k++)
            expected_glyphs.push_back(render_glyph(CODE_ZERO + digits[n - 1 - k], k == n - 1));
         n_values++;
      end
   endtask

   task automatic send_request(input logic func, input logic [7:0] code,
                               input logic [31:0] number);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_func      <= func;
      req_char_code <= code;
      req_number    <= number;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(func, code, number);
   endtask

   always @(posedge clock) begin
      glyph_result_t seen;
      glyph_result_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_col_pad_left, rsp_col_a, rsp_col_b, rsp_col_c, rsp_col_d,
                     rsp_col_e, rsp_col_pad_right, rsp_shown_code, rsp_bad_code, rsp_last};
            n_glyphs++;
            if (expected_glyphs.size() == 0) begin
               failures++;
               if (reported < REPORT_MAX) begin
                  reported++;
                  $display("unexpected glyph: code %h cols %h %h %h %h %h bad %b last %b",
                           seen.shown_code, seen.col_a, seen.col_b, seen.col_c, seen.col_d,
                           seen.col_e, seen.bad_code, seen.last);
               end
            end else begin
               want = expected_glyphs.pop_front();
               if (seen !== want) begin
                  failures++;
                  if (reported < REPORT_MAX) begin
                     reported++;
                     $display("glyph mismatch at %0t", $realtime);
                     $display("  expected: pad %b code %h cols %h %h %h %h %h pad %b bad %b last %b",
                              want.col_pad_left, want.shown_code, want.col_a, want.col_b,
                              want.col_c, want.col_d, want.col_e, want.col_pad_right,
                              want.bad_code, want.last);
                     $display("  actual:   pad %b code %h cols %h %h %h %h %h pad %b bad %b last %b",
                              seen.col_pad_left, seen.shown_code, seen.col_a, seen.col_b,
                              seen.col_c, seen.col_d, seen.col_e, seen.col_pad_right,
                              seen.bad_code, seen.last);
                  end
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic logic [31:0] random_number();
      logic [31:0] p;
      p = 32'd1;
      case ($urandom_range(4))
         0: return $urandom_range(9);
         1: return $urandom_range(99999);
         2: begin
            repeat ($urandom_range(9)) p = p * 10;
            return p - $urandom_range(1);
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic random_request();
      if ($urandom_range(1))
         send_request(FUNC_VALUE, 8'($urandom_range(255)), random_number());
      else
         send_request(FUNC_CHAR, 8'($urandom_range(255)), $urandom());
   endtask

   task automatic test_char_edges();
      logic [7:0] codes [10] = '{8'h00, 8'h1f, 8'h20, 8'h21, 8'h41, 8'h7e,
                                 8'h7f, 8'h80, 8'hc5, 8'hff};
      foreach (codes[i]) send_request(FUNC_CHAR, codes[i], 32'hffff_ffff);
   endtask

   task automatic test_value_edges();
      logic [31:0] values [9] = '{32'd0, 32'd9, 32'd10, 32'd99, 32'd100,
                                  32'd999_999_999, 32'd1_000_000_000,
                                  32'd4_000_000_001, 32'hffff_ffff};
      foreach (values[i]) send_request(FUNC_VALUE, 8'hff, values[i]);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) random_request();
   endtask

   task automatic test_back_to_back(input int count);
      quiet = 1'b1;
      repeat (count) random_request();
      quiet = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_char_edges();
      test_value_edges();
      test_random_mix(150);
      test_back_to_back(70);
      test_random_mix(71);
      req_valid <= 1'b0;
      while (expected_glyphs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      failures += expected_glyphs.size();
      $display("covered %0d character items and %0d value items, %0d glyphs checked",
               n_chars, n_values, n_glyphs);
      $display("%0d failures", failures);
      if (failures == 0)
         $display("PASS decimal_value_glyph_renderer");
      else
         $display("FAIL decimal_value_glyph_renderer");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d glyphs outstanding", expected_glyphs.size());
      $display("FAIL decimal_value_glyph_renderer");
      $finish;
   end

endmodule
